### sv/vertex_one_ring_classifier_unit_defines.svh
// Assertion macros used by the one-ring classifier sequencer.
`ifndef VERTEX_ONE_RING_CLASSIFIER_UNIT_DEFINES_SVH
`define VERTEX_ONE_RING_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk out of reset.
`define VORC_ASSERT_NOW(label, ant, con) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("vorc check failed");

// Next-cycle implication, checked on clk out of reset.
`define VORC_ASSERT_NEXT(label, ant, con) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("vorc check failed");

`endif

### sv/vorc_pkg.sv
// Shared constants and types of the vertex one-ring classifier.
`default_nettype none
package vorc_pkg;

  // Vertex and face id width, fixed by the channel fields.
  localparam int IdBits = 32;
  // Default entry store depth.
  localparam int MaxFacesDef = 16;
  // Most results emitted for one vertex, and the counter width for it.
  localparam int ResultCap = 32;
  localparam int ResWidth = $clog2(ResultCap + 1);

  // One kept triangle: face id and the two corners after the center vertex.
  typedef struct packed {
    logic [IdBits-1:0] face;
    logic [IdBits-1:0] first;
    logic [IdBits-1:0] second;
  } vorc_entry_t;

  // Write enables from the sequencer to the store.
  typedef struct packed {
    logic ent_we;
    logic chain_we;
  } vorc_store_ctl_t;

endpackage
`default_nettype wire

### sv/vorc_store.sv
// Entry memory and chain-order memory, one write and one registered read each.
`default_nettype none
module vorc_store #(
  parameter int MAX_FACES = vorc_pkg::MaxFacesDef
) (
  input  wire                           clk,
  input  wire vorc_pkg::vorc_store_ctl_t ctl,
  input  wire [$clog2(MAX_FACES)-1:0]   ent_waddr,
  input  wire vorc_pkg::vorc_entry_t    ent_wdata,
  input  wire [$clog2(MAX_FACES)-1:0]   ent_raddr,
  output vorc_pkg::vorc_entry_t         ent_rdata,
  input  wire [$clog2(2*MAX_FACES)-1:0] chain_waddr,
  input  wire [$clog2(MAX_FACES)-1:0]   chain_wdata,
  input  wire [$clog2(2*MAX_FACES)-1:0] chain_raddr,
  output logic [$clog2(MAX_FACES)-1:0]  chain_rdata
);

  localparam int IW = $clog2(MAX_FACES);
  localparam int ChainDepth = 2 * MAX_FACES;

  vorc_pkg::vorc_entry_t ent_mem [MAX_FACES];
  logic [IW-1:0]         chain_mem [ChainDepth];

  // Write and read the entry store
  always_ff @(posedge clk) begin
    if (ctl.ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata <= ent_mem[ent_raddr];
  end

  // Write and read the chain deque
  always_ff @(posedge clk) begin
    if (ctl.chain_we) begin
      chain_mem[chain_waddr] <= chain_wdata;
    end
    chain_rdata <= chain_mem[chain_raddr];
  end

endmodule
`default_nettype wire

### sv/vorc_ctrl.sv
// Sequencer: loads entries, chains the fan, classifies and emits results.
`default_nettype none
`include "vertex_one_ring_classifier_unit_defines.svh"
module vorc_ctrl #(
  parameter int MAX_FACES = vorc_pkg::MaxFacesDef
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire [31:0]                         in_center_vertex,
  input  wire [31:0]                         in_face_index,
  input  wire [31:0]                         in_corner_zero,
  input  wire [31:0]                         in_corner_one,
  input  wire [31:0]                         in_corner_two,
  input  wire                                in_face_present,
  input  wire                                in_final_face,
  input  wire                                in_valid,
  output logic                               in_stall,
  output logic [1:0]                         out_vertex_kind,
  output logic [31:0]                        out_face,
  output logic                               out_face_valid,
  output logic [31:0]                        out_neighbor,
  output logic                               out_neighbor_valid,
  output logic                               out_overflow,
  output logic                               out_run_end,
  output logic                               out_valid,
  input  wire                                out_stall,
  output vorc_pkg::vorc_store_ctl_t          st_ctl,
  output logic [$clog2(MAX_FACES)-1:0]       ent_waddr,
  output vorc_pkg::vorc_entry_t              ent_wdata,
  output logic [$clog2(MAX_FACES)-1:0]       ent_raddr,
  input  wire vorc_pkg::vorc_entry_t         ent_rdata,
  output logic [$clog2(2*MAX_FACES)-1:0]     chain_waddr,
  output logic [$clog2(MAX_FACES)-1:0]       chain_wdata,
  output logic [$clog2(2*MAX_FACES)-1:0]     chain_raddr,
  input  wire [$clog2(MAX_FACES)-1:0]        chain_rdata
);

  localparam int IW = $clog2(MAX_FACES);
  localparam int CW = $clog2(MAX_FACES + 1);
  localparam int PW = $clog2(2 * MAX_FACES);
  localparam int RW = vorc_pkg::ResWidth;
  localparam int DW = vorc_pkg::IdBits;

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_INIT2, S_ORD, S_CLASS, S_CNT, S_CEMIT,
    S_EMIT_C, S_EMIT_E, S_EMIT_D, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    KIND_UNREF, KIND_SIMPLE, KIND_BORDER, KIND_COMPLEX
  } kind_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [MAX_FACES-1:0] used_r, used_nxt;
  logic [DW-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic [PW-1:0]    hptr_r, hptr_nxt, tptr_r, tptr_nxt;
  logic [CW-1:0]    len_r, len_nxt, left_r, left_nxt;
  logic [CW-1:0]    sc_r, sc_nxt;
  logic             sc_on_r, sc_on_nxt, rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]    rd_idx_r, rd_idx_nxt;
  kind_t            kind_r, kind_nxt;
  logic [RW-1:0]    k_r, k_nxt, total_r, total_nxt, nv_r, nv_nxt;
  logic [DW-1:0]    prev_r, prev_nxt, best_r, best_nxt, fcap_r, fcap_nxt;
  logic             prev_vld_r, prev_vld_nxt, best_vld_r, best_vld_nxt;
  logic             ov_r, ov_nxt, o_fv_r, o_fv_nxt, o_nv_r, o_nv_nxt;
  logic             o_ovf_r, o_ovf_nxt, o_end_r, o_end_nxt;
  kind_t            o_kind_r, o_kind_nxt;
  logic [DW-1:0]    o_face_r, o_face_nxt, o_nb_r, o_nb_nxt;

  logic             in_xfer, out_xfer, hit, scan_last;
  logic [DW-1:0]    sel_first, sel_second, bst, fnow;
  logic             bv;
  logic [RW-1:0]    tsum;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = ov_r && !out_stall;
  assign in_stall = (state_r != S_LOAD);
  assign scan_last = rd_vld_r && (CW'(rd_idx_r) == cnt_r - CW'(1));

  // Find the center among the corners, earliest corner first
  always_comb begin
    hit = 1'b1;
    sel_first = in_corner_one;
    sel_second = in_corner_two;
    if (in_corner_zero == in_center_vertex) begin
      sel_first = in_corner_one;
      sel_second = in_corner_two;
    end else if (in_corner_one == in_center_vertex) begin
      sel_first = in_corner_two;
      sel_second = in_corner_zero;
    end else if (in_corner_two == in_center_vertex) begin
      sel_first = in_corner_zero;
      sel_second = in_corner_one;
    end else begin
      hit = 1'b0;
    end
  end

  // Smallest corner above the last counted or emitted neighbor, folded in per entry
  always_comb begin
    bst = best_r;
    bv = best_vld_r;
    if (rd_vld_r) begin
      if ((!prev_vld_r || ent_rdata.first > prev_r) && (!bv || ent_rdata.first < bst)) begin
        bst = ent_rdata.first;
        bv = 1'b1;
      end
      if ((!prev_vld_r || ent_rdata.second > prev_r) &&
          (!bv || ent_rdata.second < bst)) begin
        bst = ent_rdata.second;
        bv = 1'b1;
      end
    end
    fnow = (rd_vld_r && RW'(rd_idx_r) == k_r) ? ent_rdata.face : fcap_r;
  end

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    used_nxt = used_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    hptr_nxt = hptr_r;
    tptr_nxt = tptr_r;
    len_nxt = len_r;
    left_nxt = left_r;
    kind_nxt = kind_r;
    k_nxt = k_r;
    total_nxt = total_r;
    nv_nxt = nv_r;
    prev_nxt = prev_r;
    prev_vld_nxt = prev_vld_r;
    best_nxt = best_r;
    best_vld_nxt = best_vld_r;
    fcap_nxt = fcap_r;
    ov_nxt = ov_r;
    o_kind_nxt = o_kind_r;
    o_face_nxt = o_face_r;
    o_fv_nxt = o_fv_r;
    o_nb_nxt = o_nb_r;
    o_nv_nxt = o_nv_r;
    o_ovf_nxt = o_ovf_r;
    o_end_nxt = o_end_r;
    tsum = '0;
    st_ctl = '0;
    ent_waddr = cnt_r[IW-1:0];
    ent_wdata.face = in_face_index;
    ent_wdata.first = sel_first;
    ent_wdata.second = sel_second;
    ent_raddr = sc_r[IW-1:0];
    chain_waddr = hptr_r;
    chain_wdata = rd_idx_r;
    chain_raddr = hptr_r + PW'(k_r);

    // Advance the scan address stream
    sc_nxt = sc_r;
    sc_on_nxt = sc_on_r;
    rd_idx_nxt = rd_idx_r;
    rd_vld_nxt = 1'b0;
    if (sc_on_r) begin
      rd_vld_nxt = 1'b1;
      rd_idx_nxt = sc_r[IW-1:0];
      sc_nxt = sc_r + CW'(1);
      sc_on_nxt = (sc_r != cnt_r - CW'(1));
    end

    case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (in_face_present && hit) begin
            if (cnt_r < CW'(MAX_FACES)) begin
              st_ctl.ent_we = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (in_final_face) begin
            if (cnt_nxt == '0) begin
              ov_nxt = 1'b1;
              o_kind_nxt = KIND_UNREF;
              o_fv_nxt = 1'b0;
              o_face_nxt = '0;
              o_nv_nxt = 1'b0;
              o_nb_nxt = '0;
              o_ovf_nxt = ovf_nxt;
              o_end_nxt = 1'b1;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_INIT;
            end
          end
        end
      end
      S_INIT: begin
        // Seed the chain with the first kept entry
        ent_raddr = '0;
        st_ctl.chain_we = 1'b1;
        chain_waddr = PW'(MAX_FACES);
        chain_wdata = '0;
        hptr_nxt = PW'(MAX_FACES);
        tptr_nxt = PW'(MAX_FACES);
        state_nxt = S_INIT2;
      end
      S_INIT2: begin
        head_nxt = ent_rdata.first;
        tail_nxt = ent_rdata.second;
        used_nxt = {{(MAX_FACES-1){1'b0}}, 1'b1};
        len_nxt = CW'(1);
        left_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = S_CLASS;
        end else begin
          sc_nxt = '0;
          sc_on_nxt = 1'b1;
          rd_vld_nxt = 1'b0;
          state_nxt = S_ORD;
        end
      end
      S_ORD: begin
        if (rd_vld_r && !used_r[rd_idx_r] &&
            (ent_rdata.second == head_r || ent_rdata.first == tail_r)) begin
          // Place the entry in front or at the back, then rescan while entries are left
          st_ctl.chain_we = 1'b1;
          if (ent_rdata.second == head_r) begin
            chain_waddr = hptr_r - PW'(1);
            hptr_nxt = hptr_r - PW'(1);
            head_nxt = ent_rdata.first;
          end else begin
            chain_waddr = tptr_r + PW'(1);
            tptr_nxt = tptr_r + PW'(1);
            tail_nxt = ent_rdata.second;
          end
          used_nxt[rd_idx_r] = 1'b1;
          len_nxt = len_r + CW'(1);
          left_nxt = left_r - CW'(1);
          rd_vld_nxt = 1'b0;
          if (left_r == CW'(1)) begin
            sc_on_nxt = 1'b0;
            state_nxt = S_CLASS;
          end else begin
            sc_nxt = '0;
            sc_on_nxt = 1'b1;
          end
        end else if (scan_last) begin
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        k_nxt = '0;
        if (left_r != '0) begin
          kind_nxt = KIND_COMPLEX;
          nv_nxt = '0;
          prev_vld_nxt = 1'b0;
          best_vld_nxt = 1'b0;
          sc_nxt = '0;
          sc_on_nxt = 1'b1;
          state_nxt = S_CNT;
        end else begin
          kind_nxt = (head_r == tail_r) ? KIND_SIMPLE : KIND_BORDER;
          tsum = RW'(len_r) + ((head_r == tail_r) ? RW'(0) : RW'(1));
          total_nxt = (tsum > RW'(vorc_pkg::ResultCap)) ? RW'(vorc_pkg::ResultCap) : tsum;
          state_nxt = S_EMIT_C;
        end
      end
      S_CNT: begin
        // Count distinct neighbors, one ascending step per scan
        best_nxt = bst;
        best_vld_nxt = bv;
        if (scan_last) begin
          if (bv && nv_r + RW'(1) != RW'(vorc_pkg::ResultCap)) begin
            nv_nxt = nv_r + RW'(1);
            prev_nxt = bst;
            prev_vld_nxt = 1'b1;
            best_vld_nxt = 1'b0;
            sc_nxt = '0;
            sc_on_nxt = 1'b1;
          end else begin
            nv_nxt = bv ? nv_r + RW'(1) : nv_r;
            total_nxt = (RW'(cnt_r) > nv_nxt) ? RW'(cnt_r) : nv_nxt;
            prev_vld_nxt = 1'b0;
            best_vld_nxt = 1'b0;
            sc_nxt = '0;
            sc_on_nxt = 1'b1;
            state_nxt = S_CEMIT;
          end
        end
      end
      S_CEMIT: begin
        best_nxt = bst;
        best_vld_nxt = bv;
        fcap_nxt = fnow;
        if (scan_last) begin
          ov_nxt = 1'b1;
          o_kind_nxt = KIND_COMPLEX;
          o_fv_nxt = (k_r < RW'(cnt_r));
          o_face_nxt = (k_r < RW'(cnt_r)) ? fnow : '0;
          o_nv_nxt = (k_r < nv_r);
          o_nb_nxt = (k_r < nv_r) ? bst : '0;
          o_ovf_nxt = ovf_r;
          o_end_nxt = (k_r == total_r - RW'(1));
          prev_nxt = bst;
          prev_vld_nxt = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_EMIT_C: begin
        if (RW'(len_r) > k_r) begin
          state_nxt = S_EMIT_E;
        end else begin
          // Border tail: neighbor only
          ov_nxt = 1'b1;
          o_kind_nxt = kind_r;
          o_fv_nxt = 1'b0;
          o_face_nxt = '0;
          o_nv_nxt = 1'b1;
          o_nb_nxt = tail_r;
          o_ovf_nxt = ovf_r;
          o_end_nxt = (k_r == total_r - RW'(1));
          state_nxt = S_OUT;
        end
      end
      S_EMIT_E: begin
        ent_raddr = chain_rdata;
        state_nxt = S_EMIT_D;
      end
      S_EMIT_D: begin
        ov_nxt = 1'b1;
        o_kind_nxt = kind_r;
        o_fv_nxt = 1'b1;
        o_face_nxt = ent_rdata.face;
        o_nv_nxt = 1'b1;
        o_nb_nxt = ent_rdata.first;
        o_ovf_nxt = ovf_r;
        o_end_nxt = (k_r == total_r - RW'(1));
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Hold the result until the transfer, then step or finish
        if (out_xfer) begin
          ov_nxt = 1'b0;
          if (o_end_r) begin
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt = k_r + RW'(1);
            if (kind_r == KIND_COMPLEX) begin
              best_vld_nxt = 1'b0;
              sc_nxt = '0;
              sc_on_nxt = 1'b1;
              state_nxt = S_CEMIT;
            end else begin
              state_nxt = S_EMIT_C;
            end
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      sc_on_r <= 1'b0;
      rd_vld_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      sc_on_r <= sc_on_nxt;
      rd_vld_r <= rd_vld_nxt;
      ov_r <= ov_nxt;
      used_r <= used_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      hptr_r <= hptr_nxt;
      tptr_r <= tptr_nxt;
      len_r <= len_nxt;
      left_r <= left_nxt;
      sc_r <= sc_nxt;
      rd_idx_r <= rd_idx_nxt;
      kind_r <= kind_nxt;
      k_r <= k_nxt;
      total_r <= total_nxt;
      nv_r <= nv_nxt;
      prev_r <= prev_nxt;
      prev_vld_r <= prev_vld_nxt;
      best_r <= best_nxt;
      best_vld_r <= best_vld_nxt;
      fcap_r <= fcap_nxt;
      o_kind_r <= o_kind_nxt;
      o_face_r <= o_face_nxt;
      o_fv_r <= o_fv_nxt;
      o_nb_r <= o_nb_nxt;
      o_nv_r <= o_nv_nxt;
      o_ovf_r <= o_ovf_nxt;
      o_end_r <= o_end_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_vertex_kind = o_kind_r;
  assign out_face = o_face_r;
  assign out_face_valid = o_fv_r;
  assign out_neighbor = o_nb_r;
  assign out_neighbor_valid = o_nv_r;
  assign out_overflow = o_ovf_r;
  assign out_run_end = o_end_r;

  `VORC_ASSERT_NOW(a_out_only_in_out, ov_r, state_r == S_OUT)
  `VORC_ASSERT_NEXT(a_clear_after_run, out_xfer && o_end_r, cnt_r == '0 && !ovf_r)
  `VORC_ASSERT_NOW(a_chain_shorter, state_r == S_ORD, len_r < cnt_r && left_r != '0)
  `VORC_ASSERT_NOW(a_deque_order, state_r == S_ORD || state_r == S_EMIT_C,
                   hptr_r <= tptr_r)

endmodule
`default_nettype wire

### sv/vertex_one_ring_classifier_unit.sv
// Vertex one-ring classifier: orders the triangles around one vertex into a fan.
//
// Input channel (in_*): one triangle per transfer; in_final_face marks the last
// one of a vertex. Triangles that do not contain in_center_vertex are dropped,
// and triangles beyond MAX_FACES set the overflow flag of the run.
// Output channel (out_*): one transfer per ordered face and neighbor pair;
// out_run_end marks the last one of the vertex.
// Loading takes the triangles while the input does not stall. After the final
// triangle the chain builder rescans the entry memory, one entry per cycle, once
// per placed face. Each result of a simple or border vertex then passes through
// a chain read, an entry read, an output load and the transfer. For a complex
// vertex a full memory scan counts each distinct neighbor, and another full
// scan finds each sorted neighbor for its result.
// The input stalls from the final triangle until the last result is taken.
// A stalled output holds its result; the block waits on it.
// Reset (synchronous, active low) empties the store and drops any run.
`default_nettype none
module vertex_one_ring_classifier_unit #(
  parameter int MAX_FACES = vorc_pkg::MaxFacesDef
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire  [31:0] in_center_vertex,
  input  wire  [31:0] in_face_index,
  input  wire  [31:0] in_corner_zero,
  input  wire  [31:0] in_corner_one,
  input  wire  [31:0] in_corner_two,
  input  wire         in_face_present,
  input  wire         in_final_face,
  input  wire         in_valid,
  output logic        in_stall,
  output logic [1:0]  out_vertex_kind,
  output logic [31:0] out_face,
  output logic        out_face_valid,
  output logic [31:0] out_neighbor,
  output logic        out_neighbor_valid,
  output logic        out_overflow,
  output logic        out_run_end,
  output logic        out_valid,
  input  wire         out_stall
);

  localparam int IW = $clog2(MAX_FACES);
  localparam int PW = $clog2(2 * MAX_FACES);

  vorc_pkg::vorc_store_ctl_t st_ctl;
  vorc_pkg::vorc_entry_t     ent_wdata, ent_rdata;
  logic [IW-1:0]             ent_waddr, ent_raddr, chain_wdata, chain_rdata;
  logic [PW-1:0]             chain_waddr, chain_raddr;

  // Sequencer
  vorc_ctrl #(.MAX_FACES(MAX_FACES)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_center_vertex(in_center_vertex), .in_face_index(in_face_index),
    .in_corner_zero(in_corner_zero), .in_corner_one(in_corner_one),
    .in_corner_two(in_corner_two), .in_face_present(in_face_present),
    .in_final_face(in_final_face), .in_valid(in_valid), .in_stall(in_stall),
    .out_vertex_kind(out_vertex_kind), .out_face(out_face),
    .out_face_valid(out_face_valid), .out_neighbor(out_neighbor),
    .out_neighbor_valid(out_neighbor_valid), .out_overflow(out_overflow),
    .out_run_end(out_run_end), .out_valid(out_valid), .out_stall(out_stall),
    .st_ctl(st_ctl), .ent_waddr(ent_waddr), .ent_wdata(ent_wdata),
    .ent_raddr(ent_raddr), .ent_rdata(ent_rdata),
    .chain_waddr(chain_waddr), .chain_wdata(chain_wdata),
    .chain_raddr(chain_raddr), .chain_rdata(chain_rdata)
  );

  // Entry and chain memories
  vorc_store #(.MAX_FACES(MAX_FACES)) u_store (
    .clk(clk), .ctl(st_ctl),
    .ent_waddr(ent_waddr), .ent_wdata(ent_wdata),
    .ent_raddr(ent_raddr), .ent_rdata(ent_rdata),
    .chain_waddr(chain_waddr), .chain_wdata(chain_wdata),
    .chain_raddr(chain_raddr), .chain_rdata(chain_rdata)
  );

endmodule
`default_nettype wire

### sim/vorc_result_checker.sv
// Checker for the vertex one-ring classifier: predicts fan results and compares.
`timescale 1ns / 1ps
`default_nettype none
module vorc_result_checker #(
  parameter int MAX_FACES = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire  [31:0] in_center_vertex,
  input  wire  [31:0] in_face_index,
  input  wire  [31:0] in_corner_zero,
  input  wire  [31:0] in_corner_one,
  input  wire  [31:0] in_corner_two,
  input  wire         in_face_present,
  input  wire         in_final_face,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire  [1:0]  out_vertex_kind,
  input  wire  [31:0] out_face,
  input  wire         out_face_valid,
  input  wire  [31:0] out_neighbor,
  input  wire         out_neighbor_valid,
  input  wire         out_overflow,
  input  wire         out_run_end,
  input  wire         out_valid,
  input  wire         out_stall,
  output int          fail_count,
  output int          pending_count,
  output int          result_count,
  output int          vertex_count
);

  localparam logic [1:0] KindUnref   = 2'd0;
  localparam logic [1:0] KindSimple  = 2'd1;
  localparam logic [1:0] KindBorder  = 2'd2;
  localparam logic [1:0] KindComplex = 2'd3;
  localparam int ExpDepth = 256;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] face;
    logic        face_ok;
    logic [31:0] nbr;
    logic        nbr_ok;
    logic        ovf;
    logic        last;
  } fan_result_t;

  // expected results, ring buffer with running write and read counts
  fan_result_t exp_mem[ExpDepth];
  int          exp_wr;
  int          exp_rd;

  // predictor copy of the entry store
  logic [31:0] kept_face[MAX_FACES];
  logic [31:0] kept_first[MAX_FACES];
  logic [31:0] kept_second[MAX_FACES];
  int          kept_count;
  logic        dropped_seen;

  assign pending_count = exp_wr - exp_rd;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic expect_result(input fan_result_t r);
    exp_mem[exp_wr % ExpDepth] = r;
    exp_wr++;
  endtask

  // order the kept entries into a fan and queue the results
  task automatic build_fan();
    int          order[MAX_FACES];
    int          len;
    bit          taken[MAX_FACES];
    logic [31:0] fc[MAX_FACES];
    logic [31:0] nb[2*MAX_FACES+1];
    int          nf, nv;
    logic [31:0] head, tail;
    logic [1:0]  kind;
    int          total, p;
    bit          fit;
    fan_result_t r;
    if (kept_count == 0) begin
      r = '{KindUnref, 32'd0, 1'b0, 32'd0, 1'b0, dropped_seen, 1'b1};
      expect_result(r);
      return;
    end
    nf = 0;
    nv = 0;
    foreach (taken[i]) taken[i] = 0;
    order[0] = 0;
    len = 1;
    taken[0] = 1;
    fit = 1;
    while (len < kept_count && fit) begin
      head = kept_first[order[0]];
      tail = kept_second[order[len-1]];
      fit = 0;
      for (int i = 0; i < kept_count && !fit; i++) begin
        if (!taken[i]) begin
          if (kept_second[i] == head) begin
            for (int q = len; q > 0; q--) order[q] = order[q-1];
            order[0] = i;
            fit = 1;
          end else if (kept_first[i] == tail) begin
            order[len] = i;
            fit = 1;
          end
          if (fit) begin
            taken[i] = 1;
            len++;
          end
        end
      end
    end
    if (len < kept_count) begin
      kind = KindComplex;
      for (int i = 0; i < kept_count; i++) begin
        fc[nf] = kept_face[i];
        nf++;
        for (int j = 0; j < 2; j++) begin
          logic [31:0] v;
          v = (j == 0) ? kept_first[i] : kept_second[i];
          p = 0;
          while (p < nv && nb[p] < v) p++;
          if (!(p < nv && nb[p] == v)) begin
            for (int q = nv; q > p; q--) nb[q] = nb[q-1];
            nb[p] = v;
            nv++;
          end
        end
      end
    end else begin
      head = kept_first[order[0]];
      tail = kept_second[order[len-1]];
      kind = (head == tail) ? KindSimple : KindBorder;
      for (int i = 0; i < len; i++) begin
        fc[nf] = kept_face[order[i]];
        nf++;
        nb[nv] = kept_first[order[i]];
        nv++;
      end
      if (kind == KindBorder) begin
        nb[nv] = tail;
        nv++;
      end
    end
    total = (nf > nv) ? nf : nv;
    if (total > vorc_pkg::ResultCap) total = vorc_pkg::ResultCap;
    for (int k = 0; k < total; k++) begin
      r.kind    = kind;
      r.face_ok = k < nf;
      r.face    = r.face_ok ? fc[k] : 32'd0;
      r.nbr_ok  = k < nv;
      r.nbr     = r.nbr_ok ? nb[k] : 32'd0;
      r.ovf     = dropped_seen;
      r.last    = (k == total - 1);
      expect_result(r);
    end
  endtask

  // accept a triangle transfer and update the predictor
  task automatic take_triangle();
    logic [31:0] c[3];
    c[0] = in_corner_zero;
    c[1] = in_corner_one;
    c[2] = in_corner_two;
    if (in_face_present) begin
      for (int j = 0; j < 3; j++) begin
        if (c[j] == in_center_vertex) begin
          if (kept_count < MAX_FACES) begin
            kept_face[kept_count]   = in_face_index;
            kept_first[kept_count]  = c[(j+1)%3];
            kept_second[kept_count] = c[(j+2)%3];
            kept_count++;
          end else begin
            dropped_seen = 1;
          end
          break;
        end
      end
    end
    if (in_final_face) begin
      build_fan();
      kept_count   = 0;
      dropped_seen = 0;
      vertex_count++;
    end
  endtask

  // compare a result transfer with the oldest expectation
  task automatic check_result();
    fan_result_t w;
    if (exp_wr == exp_rd) begin
      report_mismatch("unexpected result", out_face, 32'd0);
      return;
    end
    w = exp_mem[exp_rd % ExpDepth];
    exp_rd++;
    result_count++;
    if (out_vertex_kind != w.kind)
      report_mismatch("vertex_kind", 32'(out_vertex_kind), 32'(w.kind));
    if (out_face != w.face) report_mismatch("face", out_face, w.face);
    if (out_face_valid != w.face_ok)
      report_mismatch("face_valid", 32'(out_face_valid), 32'(w.face_ok));
    if (out_neighbor != w.nbr) report_mismatch("neighbor", out_neighbor, w.nbr);
    if (out_neighbor_valid != w.nbr_ok)
      report_mismatch("neighbor_valid", 32'(out_neighbor_valid), 32'(w.nbr_ok));
    if (out_overflow != w.ovf)
      report_mismatch("overflow", 32'(out_overflow), 32'(w.ovf));
    if (out_run_end != w.last)
      report_mismatch("run_end", 32'(out_run_end), 32'(w.last));
  endtask

  initial begin
    fail_count   = 0;
    result_count = 0;
    vertex_count = 0;
    kept_count   = 0;
    dropped_seen = 0;
    exp_wr       = 0;
    exp_rd       = 0;
  end

  // watch both channels at each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) take_triangle();
    end
  end

endmodule
`default_nettype wire

### sim/tb_vertex_one_ring_classifier_unit.sv
// Testbench top for the vertex one-ring classifier: stimulus, idling and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_vertex_one_ring_classifier_unit;

  localparam int MaxFaces = vorc_pkg::MaxFacesDef;
  localparam int IdleLimit = 20000;
  localparam int TriDepth = 128;

  logic        clk = 0;
  logic        rst_n = 0;
  logic [31:0] in_center_vertex = 0;
  logic [31:0] in_face_index = 0;
  logic [31:0] in_corner_zero = 0;
  logic [31:0] in_corner_one = 0;
  logic [31:0] in_corner_two = 0;
  logic        in_face_present = 0;
  logic        in_final_face = 0;
  logic        in_valid = 0;
  logic        out_stall = 0;
  wire         in_stall;
  wire  [1:0]  out_vertex_kind;
  wire  [31:0] out_face;
  wire         out_face_valid;
  wire  [31:0] out_neighbor;
  wire         out_neighbor_valid;
  wire         out_overflow;
  wire         out_run_end;
  wire         out_valid;

  int fail_count, pending_count, result_count, vertex_count;
  int triangles_sent;
  int idle_cycles;
  bit hold_off_req;
  bit stim_done;

  // one triangle waiting to be offered
  typedef struct {
    logic [31:0] ctr;
    logic [31:0] fid;
    logic [31:0] c0, c1, c2;
    logic        present;
    logic        last;
  } triangle_t;

  // triangles of the current batch, filled then drained in order
  triangle_t tri_buf[TriDepth];
  int        tri_wr;
  int        tri_rd;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  vertex_one_ring_classifier_unit #(.MAX_FACES(MaxFaces)) u_top (.*);

  vorc_result_checker #(.MAX_FACES(MaxFaces)) u_checker (.*);

  function automatic int short_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic logic [31:0] rand_id();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_tri(input triangle_t t);
    tri_buf[tri_wr] = t;
    tri_wr++;
  endtask

  // queue one triangle: rotate so the center lands on corner position pos
  task automatic add_tri(input logic [31:0] ctr, input logic [31:0] fid,
                         input logic [31:0] a, input logic [31:0] b,
                         input int pos, input bit last);
    triangle_t t;
    t.ctr = ctr;
    t.fid = fid;
    t.present = 1;
    t.last = last;
    case (pos)
      0: begin t.c0 = ctr; t.c1 = a; t.c2 = b; end
      1: begin t.c0 = b; t.c1 = ctr; t.c2 = a; end
      default: begin t.c0 = a; t.c1 = b; t.c2 = ctr; end
    endcase
    queue_tri(t);
  endtask

  // queue a fan of n faces around ctr, closed or open, optionally shuffled
  task automatic add_fan(input logic [31:0] ctr, input int n, input bit closed,
                         input bit shuffle, input int noise);
    logic [31:0] ring[MaxFaces+3];
    int          idx[MaxFaces+2];
    int          m, j, r, s;
    triangle_t   t;
    m = closed ? n : n + 1;
    for (int i = 0; i < m; i++) ring[i] = ctr ^ (32'h100 + i * 7 + $urandom_range(0, 3));
    for (int i = 0; i < n; i++) idx[i] = i;
    if (shuffle) begin
      for (int i = n - 1; i > 0; i--) begin
        r = $urandom_range(0, i);
        s = idx[i];
        idx[i] = idx[r];
        idx[r] = s;
      end
    end
    for (int i = 0; i < n; i++) begin
      j = idx[i];
      if (noise > 0 && $urandom_range(0, 3) == 0) begin
        t.ctr = ctr; t.fid = $urandom; t.c0 = $urandom; t.c1 = $urandom;
        t.c2 = $urandom; t.present = 1'($urandom_range(0, 1)); t.last = 0;
        queue_tri(t);
      end
      add_tri(ctr, $urandom, ring[j], ring[(j + 1) % m], $urandom_range(0, 2),
              i == n - 1);
    end
  endtask

  // directed cases
  task automatic queue_directed();
    triangle_t t;
    // no faces at all
    t = '{32'd5, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1};
    queue_tri(t);
    // triangle without the vertex, then final: unreferenced
    t = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd2, 32'd3, 1'b1, 1'b1};
    queue_tri(t);
    // vertex twice in one triangle, earliest corner decides
    t = '{32'd9, 32'h1234, 32'd7, 32'd9, 32'd9, 1'b1, 1'b1};
    queue_tri(t);
    // closed fan and open fan
    add_fan(32'hFFFF_FFFF, 4, 1, 0, 0);
    add_fan(32'd0, 3, 0, 1, 0);
    // complex: two disjoint wedges, max ids
    add_tri(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 0, 0);
    add_tri(32'd1, 32'h0, 32'h55, 32'hAA, 1, 1);
    // overflow: one more than the store
    add_fan(32'h77, MaxFaces + 1, 0, 0, 0);
  endtask

  // sender: offer queued triangles with random gaps
  initial begin
    int gap;
    triangle_t t;
    tri_wr = 0;
    tri_rd = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    queue_directed();
    while (triangles_sent < 360) begin
      case ($urandom_range(0, 9))
        0: add_fan($urandom, $urandom_range(1, 3), $urandom_range(0, 1), 1, 1);
        1: add_fan($urandom, MaxFaces + $urandom_range(0, 2), 1, 0, 0);
        2: begin
          // broken sequence: random triangles around the center that need not form a fan
          logic [31:0] c;
          c = rand_id();
          for (int i = 0; i < 3; i++)
            add_tri(c, rand_id(), rand_id(), rand_id(), $urandom_range(0, 2), i == 2);
        end
        3: begin
          t = '{rand_id(), rand_id(), rand_id(), rand_id(), rand_id(),
                1'($urandom_range(0, 1)), 1'b1};
          queue_tri(t);
        end
        default: add_fan($urandom, $urandom_range(3, 8), $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom_range(0, 1));
      endcase
      while (tri_rd < tri_wr) begin
        t = tri_buf[tri_rd];
        tri_rd++;
        gap = short_gap();
        // drop valid only across a real gap
        if (gap > 0) begin
          in_valid <= 0;
          repeat (gap) @(posedge clk);
        end
        in_center_vertex <= t.ctr;
        in_face_index    <= t.fid;
        in_corner_zero   <= t.c0;
        in_corner_one    <= t.c1;
        in_corner_two    <= t.c2;
        in_face_present  <= t.present;
        in_final_face    <= t.last;
        in_valid         <= 1;
        if (triangles_sent == 120) hold_off_req = 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        triangles_sent++;
      end
      tri_rd = 0;
      tri_wr = 0;
    end
    in_valid <= 0;
    stim_done = 1;
  end

  // receiver: random stalls, plus one long hold-off while the sender runs
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 0;
        out_stall <= 1;
        repeat (600) @(posedge clk);
        out_stall <= 0;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        gap = short_gap() + 1;
        out_stall <= 1;
        repeat (gap) @(posedge clk);
      end else begin
        out_stall <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // verdict
  initial begin
    wait (stim_done);
    while (pending_count != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    $display("covered %0d triangles over %0d vertices, %0d results checked",
             triangles_sent, vertex_count, result_count);
    if (fail_count == 0 && pending_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
